// ===== design/manhattan_medoid_search_unit_macros.svh =====
// Assertion helpers shared by the medoid search RTL
`ifndef MANHATTAN_MEDOID_SEARCH_UNIT_MACROS_SVH
`define MANHATTAN_MEDOID_SEARCH_UNIT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define MMS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// check that a condition implies a consequence in the following cycle
`define MMS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mms_pkg.sv =====
package mms_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_OUTER,
      ST_INNER,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

// ===== design/mms_ram.sv =====
module mms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/manhattan_medoid_search_unit.sv =====
// Throughput: one point per cycle while loading; the O(N^2) search walks a dual-read
// point memory, one pair (i, j) per cycle, and blocks input until the result is taken.
// Reset: synchronous, clears point count, drop flag and the controller; the point
// memories need no clearing, since only entries written in the current set are read.
`include "manhattan_medoid_search_unit_macros.svh"

module manhattan_medoid_search_unit #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_point_x,
   input  logic [15:0] req_point_y,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_best_x,
   output logic [15:0] rsp_best_y,
   output logic [27:0] rsp_total_distance,
   output logic        rsp_overflow
);
   import mms_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = COORD_BITS + 1;
   // exact total fits N * 2 * 2^COORD_BITS
   localparam int TW = CW + COORD_BITS + 2;
   localparam logic [TW-1:0] SUM_MAX = TW'(28'hFFFFFFF);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic          pend_ff, pend_in;     // a pair read is in flight
   logic          ilat_ff, ilat_in;     // point i read is in flight
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [TW-1:0] acc_ff, acc_in;
   logic [TW-1:0] best_t_ff, best_t_in;
   logic signed [COORD_BITS-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic          have_ff, have_in;

   logic          wr_en;
   logic [AW-1:0] rd_i, rd_j;
   logic [COORD_BITS-1:0] xi_q, yi_q, xj_q, yj_q;
   logic signed [COORD_BITS-1:0] wx, wy;

   assign wx = COORD_BITS'(req_point_x);
   assign wy = COORD_BITS'(req_point_y);
   assign req_ready = (state_ff == ST_LOAD);
   assign wr_en = req_valid && req_ready && (count_ff < CW'(MAX_POINTS));

   // two copies give two read ports: one for point i, one for point j
   mms_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_i (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data({wx, wy}), .rd_addr(rd_i), .rd_data({xi_q, yi_q}));
   mms_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_j (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data({wx, wy}), .rd_addr(rd_j), .rd_data({xj_q, yj_q}));

   assign rd_i = i_ff[AW-1:0];
   assign rd_j = j_ff[AW-1:0];

   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0] adx, ady;
   logic [TW-1:0] acc_add;
   logic better;

   always_comb begin
      dx = DW'(px_ff) - DW'($signed(xj_q));
      dy = DW'(py_ff) - DW'($signed(yj_q));
      adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
      acc_add = acc_ff + TW'(adx) + TW'(ady);
      better = !have_ff || (acc_ff < best_t_ff) ||
               (acc_ff == best_t_ff &&
                (px_ff < best_x_ff || (px_ff == best_x_ff && py_ff < best_y_ff)));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_point) begin
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            if (i_ff == count_ff) begin
               state_in = ST_RESULT;
            end else if (ilat_ff) begin
               state_in = ST_INNER;
            end
         end
         ST_INNER: begin
            if (j_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pend_ff) begin
               state_in = ST_OUTER;
            end
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      dropped_in = dropped_ff;
      i_in = i_ff;
      j_in = j_ff;
      pend_in = 1'b0;
      ilat_in = 1'b0;
      acc_in = acc_ff;
      best_t_in = best_t_ff;
      best_x_in = best_x_ff;
      best_y_in = best_y_ff;
      have_in = have_ff;
      if (pend_ff) begin
         acc_in = acc_add;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_point) begin
                  i_in = '0;
                  have_in = 1'b0;
               end
            end
         end
         ST_OUTER: begin
            j_in = '0;
            acc_in = '0;
            if (i_ff != count_ff) begin
               ilat_in = !ilat_ff;
            end
         end
         ST_INNER: begin
            if (j_ff != count_ff) begin
               j_in = j_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pend_ff) begin
               if (better) begin
                  best_t_in = acc_ff;
                  best_x_in = px_ff;
                  best_y_in = py_ff;
                  have_in = 1'b1;
               end
               i_in = i_ff + CW'(1);
            end
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               count_in = '0;
               dropped_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         pend_ff <= 1'b0;
         ilat_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
         pend_ff <= pend_in;
         ilat_ff <= ilat_in;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      acc_ff <= acc_in;
      best_t_ff <= best_t_in;
      best_x_ff <= best_x_in;
      best_y_ff <= best_y_in;
      if (ilat_ff) begin
         px_ff <= $signed(xi_q);
         py_ff <= $signed(yi_q);
      end
   end

   assign rsp_valid = (state_ff == ST_RESULT);
   assign rsp_best_x = 16'(best_x_ff);
   assign rsp_best_y = 16'(best_y_ff);
   assign rsp_total_distance = (best_t_ff > SUM_MAX) ? 28'hFFFFFFF : 28'(best_t_ff);
   assign rsp_overflow = dropped_ff;

   `MMS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS),
      "point count beyond capacity")
   `MMS_ASSERT_IMPL(a_result_found, clock, reset, rsp_valid, have_ff,
      "result shown with no candidate")
   `MMS_ASSERT_NEXT(a_clear_after, clock, reset, rsp_valid && rsp_ready,
      count_ff == '0 && !dropped_ff, "set not cleared after result")
   `MMS_ASSERT_IMPL(a_no_load_busy, clock, reset, state_ff != ST_LOAD, !wr_en,
      "point memory written during search")

endmodule
